FILE: src/sync_byte_baud_rate_hunter_core_assert.svh
// assertion macros for the baud rate hunter
`ifndef SYNC_BYTE_BAUD_RATE_HUNTER_CORE_ASSERT_SVH
`define SYNC_BYTE_BAUD_RATE_HUNTER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SBBRH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SBBRH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/sbbrh_pkg.sv
// types, codes and constants of the baud rate hunter
package sbbrh_pkg;

    // request codes
    localparam logic [1:0] REQ_BYTE    = 2'd0;
    localparam logic [1:0] REQ_VERDICT = 2'd1;
    localparam logic [1:0] REQ_RATE    = 2'd2;

    // hunt modes
    localparam logic [1:0] HUNT_OFF  = 2'd0;
    localparam logic [1:0] HUNT_LOW  = 2'd1;
    localparam logic [1:0] HUNT_HIGH = 2'd2;

    // divisor values for the known rates
    localparam logic [7:0] DIV_115K = 8'h0D;
    localparam logic [7:0] DIV_57K  = 8'h1A;
    localparam logic [7:0] DIV_38K  = 8'h27;
    localparam logic [7:0] DIV_19K  = 8'h4E;
    localparam logic [7:0] DIV_9K6  = 8'h9C;

    // sync bytes and their wrong-rate images
    localparam logic [7:0] SYNC_FF = 8'hFF;
    localparam logic [7:0] SYNC_55 = 8'h55;
    localparam logic [7:0] IMG_FE  = 8'hFE;
    localparam logic [7:0] IMG_FC  = 8'hFC;
    localparam logic [7:0] IMG_E0  = 8'hE0;

    localparam logic [2:0] BAD_LIMIT = 3'd6;

    // divider geometry: 24 MHz over 16 as the fixed dividend
    localparam int           RATE_W    = 22;
    localparam int           DIVIDEND_W = 21;
    localparam logic [DIVIDEND_W-1:0] CLK_OVER_16 = 21'd1500000;
    localparam int           STEP_W    = $clog2(DIVIDEND_W);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_DIV
    } t_state;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [7:0]        rx_byte;
        logic              in_packet;
        logic [RATE_W-1:0] bit_rate;
    } t_in_item;

    typedef struct packed {
        logic       forward_valid;
        logic [7:0] forward_byte;
        logic       divisor_write;
        logic [7:0] divisor;
        logic [1:0] search_mode;
    } t_out_item;

    // divider control and status
    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

FILE: src/sbbrh_stream_if.sv
// valid/ready stream channel carrying one payload beat
interface sbbrh_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/sbbrh_div.sv
// restoring divider: fixed dividend over a rate, one quotient bit per cycle
module sbbrh_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sbbrh_pkg::t_div_ctl               i_ctl,
    input  logic [sbbrh_pkg::RATE_W-1:0]      i_den,
    output sbbrh_pkg::t_div_stat              o_stat,
    output logic [7:0]                        o_quo
);
    logic [sbbrh_pkg::STEP_W-1:0]   r_step;
    logic                           r_busy;
    logic                           r_done;
    logic [sbbrh_pkg::RATE_W-1:0]   r_den;
    logic [sbbrh_pkg::RATE_W-1:0]   r_rem;
    logic [7:0]                     r_quo;

    logic [sbbrh_pkg::RATE_W:0]     trial;
    logic [sbbrh_pkg::RATE_W:0]     diff;
    logic                           qbit;

    // one trial subtract per cycle, dividend bits msb first
    always_comb begin
        trial = {r_rem, sbbrh_pkg::CLK_OVER_16[r_step]};
        diff  = trial - {1'b0, r_den};
        qbit  = (trial >= {1'b0, r_den});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_step <= sbbrh_pkg::STEP_W'(sbbrh_pkg::DIVIDEND_W - 1);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath, only the low quotient byte is kept
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= qbit ? diff[sbbrh_pkg::RATE_W-1:0] : trial[sbbrh_pkg::RATE_W-1:0];
            r_quo <= {r_quo[6:0], qbit};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_quo;
endmodule

FILE: src/sync_byte_baud_rate_hunter_core.sv
// top level of the sync byte baud rate hunter
//
//  channel | dir | payload     | beat rule
//  i_in    | in  | t_in_item   | valid && ready at rising edge
//  o_out   | out | t_out_item  | valid && ready at rising edge, one per input beat
//
// byte and verdict beats are registered as they are taken; set-rate beats with a
// nonzero rate go through start, 21 steps of the shared restoring divider and load.
// one beat is in work at a time; a result waits in the output register and
// the next beat is taken when that register is empty or drains the same cycle.
// synchronous active-low reset: high-speed hunt, divisor 13, packet start expected.
`include "sync_byte_baud_rate_hunter_core_assert.svh"

module sync_byte_baud_rate_hunter_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    sbbrh_stream_if.sink         i_in,
    sbbrh_stream_if.source       o_out
);
    sbbrh_pkg::t_state    r_state, n_state;
    logic [1:0]           r_hunt_mode, n_hunt_mode;
    logic [2:0]           r_bad_count, n_bad_count;
    logic                 r_pkt_next, n_pkt_next;
    logic [7:0]           r_divisor, n_divisor;
    logic                 r_out_valid;
    sbbrh_pkg::t_out_item r_out;

    sbbrh_pkg::t_in_item  item;
    sbbrh_pkg::t_out_item item_res;
    logic                 need_div;
    logic                 in_ready;
    logic                 in_fire;
    logic                 low;
    logic [2:0]           bad_inc;

    sbbrh_pkg::t_div_ctl  div_ctl;
    sbbrh_pkg::t_div_stat div_stat;
    logic [7:0]           div_quo;

    assign item    = i_in.payload;
    assign in_fire = i_in.valid && in_ready;

    // shared divider
    sbbrh_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_den   (item.bit_rate),
        .o_stat  (div_stat),
        .o_quo   (div_quo)
    );

    // item evaluation against the current hunt state
    always_comb begin
        n_hunt_mode = r_hunt_mode;
        n_bad_count = r_bad_count;
        n_pkt_next  = r_pkt_next;
        n_divisor   = r_divisor;
        need_div    = 1'b0;
        item_res    = '0;
        low         = (r_hunt_mode == sbbrh_pkg::HUNT_LOW);
        bad_inc     = r_bad_count + 3'd1;
        unique case (item.req_type)
            sbbrh_pkg::REQ_BYTE: begin
                item_res.forward_valid = 1'b1;
                item_res.forward_byte  = item.rx_byte;
                if (r_pkt_next && (r_hunt_mode != sbbrh_pkg::HUNT_OFF)) begin
                    priority if ((item.rx_byte == sbbrh_pkg::SYNC_FF) ||
                                 (item.rx_byte == sbbrh_pkg::SYNC_55)) begin
                        item_res.forward_byte = item.rx_byte;
                    end else if (!low && (item.rx_byte == sbbrh_pkg::IMG_FE)) begin
                        n_divisor              = sbbrh_pkg::DIV_57K;
                        item_res.divisor_write = 1'b1;
                        item_res.forward_byte  = sbbrh_pkg::SYNC_FF;
                    end else if (item.rx_byte == sbbrh_pkg::IMG_FC) begin
                        n_divisor = low ? sbbrh_pkg::DIV_19K : sbbrh_pkg::DIV_38K;
                        item_res.divisor_write = 1'b1;
                        item_res.forward_byte  = sbbrh_pkg::SYNC_FF;
                    end else if (item.rx_byte == sbbrh_pkg::IMG_E0) begin
                        n_divisor = low ? sbbrh_pkg::DIV_9K6 : sbbrh_pkg::DIV_19K;
                        item_res.divisor_write = 1'b1;
                        item_res.forward_byte  = sbbrh_pkg::SYNC_FF;
                    end else begin
                        // bad byte: drop, count, maybe swap hunt speed
                        item_res.forward_valid = 1'b0;
                        item_res.forward_byte  = '0;
                        item_res.divisor_write = 1'b1;
                        if (bad_inc >= sbbrh_pkg::BAD_LIMIT) begin
                            n_bad_count = '0;
                            n_hunt_mode = low ? sbbrh_pkg::HUNT_HIGH : sbbrh_pkg::HUNT_LOW;
                            n_divisor   = low ? sbbrh_pkg::DIV_115K : sbbrh_pkg::DIV_57K;
                        end else begin
                            n_bad_count = bad_inc;
                            n_divisor   = low ? sbbrh_pkg::DIV_57K : sbbrh_pkg::DIV_115K;
                        end
                    end
                end
            end
            sbbrh_pkg::REQ_VERDICT: begin
                if (r_pkt_next && !item.in_packet) begin
                    n_hunt_mode = sbbrh_pkg::HUNT_OFF;
                end
                n_pkt_next = item.in_packet;
            end
            sbbrh_pkg::REQ_RATE: begin
                item_res.divisor_write = 1'b1;
                if (item.bit_rate == '0) begin
                    n_hunt_mode = sbbrh_pkg::HUNT_HIGH;
                    n_divisor   = sbbrh_pkg::DIV_115K;
                end else begin
                    n_hunt_mode = sbbrh_pkg::HUNT_OFF;
                    need_div    = 1'b1;
                end
            end
            default: begin
                item_res = '0;
            end
        endcase
        item_res.divisor     = n_divisor;
        item_res.search_mode = n_hunt_mode;
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sbbrh_pkg::ST_IDLE: if (in_fire && need_div) n_state = sbbrh_pkg::ST_DIV;
            sbbrh_pkg::ST_DIV:  if (div_stat.done) n_state = sbbrh_pkg::ST_IDLE;
            default:            n_state = sbbrh_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        in_ready      = 1'b0;
        div_ctl.start = 1'b0;
        unique case (r_state)
            sbbrh_pkg::ST_IDLE: begin
                in_ready      = !r_out_valid || o_out.ready;
                div_ctl.start = in_fire && need_div;
            end
            sbbrh_pkg::ST_DIV: begin
                in_ready = 1'b0;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    // control and hunt state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sbbrh_pkg::ST_IDLE;
            r_hunt_mode <= sbbrh_pkg::HUNT_HIGH;
            r_bad_count <= '0;
            r_pkt_next  <= 1'b1;
            r_divisor   <= sbbrh_pkg::DIV_115K;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_fire) begin
                r_hunt_mode <= n_hunt_mode;
                r_bad_count <= n_bad_count;
                r_pkt_next  <= n_pkt_next;
                r_divisor   <= n_divisor;
            end else if (div_stat.done) begin
                r_divisor <= div_quo;
            end
            if ((in_fire && !need_div) || div_stat.done) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (in_fire && !need_div) begin
            r_out <= item_res;
        end else if (div_stat.done) begin
            r_out.forward_valid <= 1'b0;
            r_out.forward_byte  <= '0;
            r_out.divisor_write <= 1'b1;
            r_out.divisor       <= div_quo;
            r_out.search_mode   <= r_hunt_mode;
        end
    end

    assign i_in.ready    = in_ready;
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    // checks
    `SBBRH_ASSERT_NOW(a_no_take_in_div, r_state == sbbrh_pkg::ST_DIV, !in_ready, "beat taken during divide")
    `SBBRH_ASSERT_NOW(a_done_in_div, div_stat.done, r_state == sbbrh_pkg::ST_DIV, "divider done outside divide")
    `SBBRH_ASSERT_NOW(a_bad_count_range, 1'b1, r_bad_count < sbbrh_pkg::BAD_LIMIT, "bad count past limit")
    `SBBRH_ASSERT_NEXT(a_rate_starts_div, in_fire && need_div, div_stat.busy && !r_out_valid, "set-rate did not start divider")
endmodule

FILE: bench/tb_sync_byte_baud_rate_hunter_core.sv
// testbench for the baud rate hunter: random and directed beats, checked by a scoreboard
`timescale 1ns / 100ps

module tb_sync_byte_baud_rate_hunter_core;
    import sbbrh_pkg::*;

    // request code with no function in the block
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int RANDOM_BEATS = 1750;
    localparam int STALL_CYCLES = 300;
    localparam int FLOOD_BEATS = 48;
    localparam int MAX_SHOWN = 40;

    // expected results of the hunter, built from accepted request beats
    class hunt_scoreboard;
        logic [1:0] mode;
        logic [2:0] bad_bytes;
        logic       pkt_start;
        logic [7:0] div_reg;
        t_out_item  pending_results[$];
        int         errors;
        int         shown;

        function new();
            mode      = HUNT_HIGH;
            bad_bytes = 3'd0;
            pkt_start = 1'b1;
            div_reg   = DIV_115K;
            errors    = 0;
            shown     = 0;
        endfunction

        task report(input string msg);
            errors++;
            if (shown < MAX_SHOWN) begin
                $display("%0t mismatch: %s", $realtime, msg);
                shown++;
            end
        endtask

        // one bad sync byte: pick a fallback divisor or swap hunt speed
        function void count_bad_byte(input logic low);
            bad_bytes = bad_bytes + 3'd1;
            if (bad_bytes >= BAD_LIMIT) begin
                bad_bytes = 3'd0;
                if (low) begin
                    mode    = HUNT_HIGH;
                    div_reg = DIV_115K;
                end else begin
                    mode    = HUNT_LOW;
                    div_reg = DIV_57K;
                end
            end else begin
                div_reg = low ? DIV_57K : DIV_115K;
            end
        endfunction

        // advance the hunter state by one request and queue its result
        function void note_beat(input t_in_item it);
            t_out_item   r;
            logic [7:0]  b;
            logic        low;
            logic        drop;
            logic [21:0] quot;
            r    = '0;
            b    = it.rx_byte;
            drop = 1'b0;
            case (it.req_type)
                REQ_BYTE: begin
                    if (pkt_start && mode != HUNT_OFF) begin
                        low = (mode == HUNT_LOW);
                        if (b == SYNC_FF || b == SYNC_55) begin
                            // sync byte at the right rate passes as is
                        end else if (!low && b == IMG_FE) begin
                            div_reg = DIV_57K;
                            r.divisor_write = 1'b1;
                            b = SYNC_FF;
                        end else if (b == IMG_FC) begin
                            div_reg = low ? DIV_19K : DIV_38K;
                            r.divisor_write = 1'b1;
                            b = SYNC_FF;
                        end else if (b == IMG_E0) begin
                            div_reg = low ? DIV_9K6 : DIV_19K;
                            r.divisor_write = 1'b1;
                            b = SYNC_FF;
                        end else begin
                            count_bad_byte(low);
                            r.divisor_write = 1'b1;
                            drop = 1'b1;
                        end
                    end
                    if (!drop) begin
                        r.forward_valid = 1'b1;
                        r.forward_byte  = b;
                    end
                end
                REQ_VERDICT: begin
                    if (pkt_start && !it.in_packet) begin
                        mode = HUNT_OFF;
                    end
                    pkt_start = it.in_packet;
                end
                REQ_RATE: begin
                    r.divisor_write = 1'b1;
                    if (it.bit_rate == '0) begin
                        mode    = HUNT_HIGH;
                        div_reg = DIV_115K;
                    end else begin
                        mode    = HUNT_OFF;
                        quot    = CLK_OVER_16 / it.bit_rate;
                        div_reg = quot[7:0];
                    end
                end
                default: begin
                    // unused request: nothing moves
                end
            endcase
            r.divisor     = div_reg;
            r.search_mode = mode;
            pending_results.push_back(r);
        endfunction

        // compare one output beat with the oldest expected result
        task check_result(input t_out_item got);
            t_out_item want;
            if (pending_results.size() == 0) begin
                report($sformatf("result with nothing expected: %h", got));
            end else begin
                want = pending_results.pop_front();
                if (got.forward_valid !== want.forward_valid)
                    report($sformatf("forward_valid %b, want %b",
                                     got.forward_valid, want.forward_valid));
                if (got.forward_byte !== want.forward_byte)
                    report($sformatf("forward_byte %h, want %h",
                                     got.forward_byte, want.forward_byte));
                if (got.divisor_write !== want.divisor_write)
                    report($sformatf("divisor_write %b, want %b",
                                     got.divisor_write, want.divisor_write));
                if (got.divisor !== want.divisor)
                    report($sformatf("divisor %h, want %h", got.divisor, want.divisor));
                if (got.search_mode !== want.search_mode)
                    report($sformatf("search_mode %0d, want %0d",
                                     got.search_mode, want.search_mode));
            end
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    bit   stall_req = 1'b0;

    hunt_scoreboard sb = new();

    sbbrh_stream_if #(.t_payload(t_in_item))  in_ch ();
    sbbrh_stream_if #(.t_payload(t_out_item)) out_ch ();

    sync_byte_baud_rate_hunter_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // clock
    always #10 i_clk = ~i_clk;

    function automatic t_in_item make_req(input logic [1:0] kind, input logic [7:0] rx,
                                          input logic pkt, input logic [21:0] rate);
        t_in_item it;
        it.req_type  = kind;
        it.rx_byte   = rx;
        it.in_packet = pkt;
        it.bit_rate  = rate;
        return it;
    endfunction

    // random request, biased toward sync bytes while a packet start is hunted
    function automatic t_in_item gen_request();
        t_in_item it;
        int p;
        it.req_type  = REQ_BYTE;
        it.rx_byte   = 8'($urandom);
        it.in_packet = 1'($urandom);
        it.bit_rate  = 22'($urandom_range(0, 3000000));
        p = $urandom_range(0, 99);
        if (sb.mode == HUNT_OFF && p < 12) begin
            it.req_type = REQ_RATE;
            it.bit_rate = '0;
        end else if (p < 3) begin
            it.req_type = REQ_UNUSED;
        end else if (p < 10) begin
            it.req_type = REQ_RATE;
            case ($urandom_range(0, 4))
                0: it.bit_rate = '0;
                1: it.bit_rate = 22'($urandom_range(1, 64));
                2: it.bit_rate = 22'($urandom_range(1400000, 3000000));
                3: begin
                    case ($urandom_range(0, 5))
                        0: it.bit_rate = 22'd9600;
                        1: it.bit_rate = 22'd19200;
                        2: it.bit_rate = 22'd57600;
                        3: it.bit_rate = 22'd115200;
                        4: it.bit_rate = 22'd1500000;
                        default: it.bit_rate = 22'd3000000;
                    endcase
                end
                default: ;
            endcase
        end else if (p < 32) begin
            it.req_type  = REQ_VERDICT;
            it.in_packet = ($urandom_range(0, 3) != 0);
        end else if (sb.mode != HUNT_OFF && sb.pkt_start && $urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 4))
                0: it.rx_byte = SYNC_FF;
                1: it.rx_byte = SYNC_55;
                2: it.rx_byte = IMG_FE;
                3: it.rx_byte = IMG_FC;
                default: it.rx_byte = IMG_E0;
            endcase
        end
        return it;
    endfunction

    // offer one request beat after a gap; returns at the falling edge after the beat
    task automatic send_beat(input t_in_item it, input int gap);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= it;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        sb.note_beat(it);
        @(negedge i_clk);
    endtask

    task automatic send_directed(input t_in_item it);
        send_beat(it, $urandom_range(0, 11));
    endtask

    // request side
    initial begin
        bit quiet;
        int flood_left;
        int gap;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        quiet      = 1'b0;
        flood_left = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // sync bytes and wrong-rate images in the high-speed hunt
        send_directed(make_req(REQ_BYTE, SYNC_FF, 1'b0, 22'd0));
        send_directed(make_req(REQ_BYTE, SYNC_55, 1'b1, 22'h3FFFFF));
        send_directed(make_req(REQ_BYTE, IMG_FE, 1'b0, 22'd0));
        send_directed(make_req(REQ_BYTE, IMG_FC, 1'b0, 22'd0));
        send_directed(make_req(REQ_BYTE, IMG_E0, 1'b0, 22'd0));
        // six bad bytes swap to the low-speed hunt
        send_directed(make_req(REQ_BYTE, 8'h00, 1'b0, 22'd0));
        send_directed(make_req(REQ_BYTE, 8'h7F, 1'b0, 22'd0));
        send_directed(make_req(REQ_BYTE, 8'h01, 1'b0, 22'd0));
        send_directed(make_req(REQ_BYTE, 8'h80, 1'b0, 22'd0));
        send_directed(make_req(REQ_BYTE, 8'hAA, 1'b0, 22'd0));
        send_directed(make_req(REQ_BYTE, 8'hFD, 1'b0, 22'd0));
        // low-speed hunt: 0xFE counts as bad, the other images load slow divisors
        send_directed(make_req(REQ_BYTE, IMG_FE, 1'b0, 22'd0));
        send_directed(make_req(REQ_BYTE, IMG_FC, 1'b0, 22'd0));
        send_directed(make_req(REQ_BYTE, IMG_E0, 1'b0, 22'd0));
        // open verdict keeps hunting, closed verdict at packet start ends it
        send_directed(make_req(REQ_VERDICT, 8'h00, 1'b1, 22'd0));
        send_directed(make_req(REQ_VERDICT, 8'hFF, 1'b0, 22'd0));
        send_directed(make_req(REQ_BYTE, 8'h12, 1'b0, 22'd0));
        // hunting restarted mid-packet: a byte passes unchanged, and after an open verdict a bad byte is dropped
        send_directed(make_req(REQ_RATE, 8'h00, 1'b0, 22'd0));
        send_directed(make_req(REQ_BYTE, 8'h00, 1'b0, 22'd0));
        send_directed(make_req(REQ_VERDICT, 8'h00, 1'b1, 22'd0));
        send_directed(make_req(REQ_BYTE, 8'h00, 1'b0, 22'd0));
        // fixed rates, the smallest and largest among them
        send_directed(make_req(REQ_RATE, 8'h00, 1'b0, 22'd115200));
        send_directed(make_req(REQ_RATE, 8'h00, 1'b0, 22'd1));
        send_directed(make_req(REQ_RATE, 8'h00, 1'b0, 22'd1500000));
        send_directed(make_req(REQ_RATE, 8'h00, 1'b1, 22'd3000000));
        send_directed(make_req(REQ_UNUSED, 8'hFF, 1'b1, 22'h3FFFFF));

        // let every result drain before the random part
        in_ch.valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(negedge i_clk);

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 50 == 0) quiet = ($urandom_range(0, 2) == 0);
            // flood the input while the result side holds off
            if (n == 700) begin
                stall_req  = 1'b1;
                flood_left = FLOOD_BEATS;
            end
            gap = (quiet || flood_left > 0) ? 0 : $urandom_range(0, 11);
            if (flood_left > 0) flood_left--;
            send_beat(gen_request(), gap);
        end
        in_ch.valid <= 1'b0;

        // drain and settle
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sb.pending_results.size() != 0)
            sb.report("results still expected at the end");
        if (sb.errors == 0) begin
            $display("tb_sync_byte_baud_rate_hunter_core: PASS");
        end else begin
            $display("tb_sync_byte_baud_rate_hunter_core: FAIL");
        end
        $finish;
    end

    // result side
    initial begin
        bit quiet;
        int served;
        int gap;
        out_ch.ready = 1'b0;
        quiet  = 1'b0;
        served = 0;
        @(negedge i_clk);
        forever begin
            if (served % 40 == 0) quiet = ($urandom_range(0, 2) == 0);
            if (stall_req) begin
                gap       = STALL_CYCLES;
                stall_req = 1'b0;
            end else begin
                gap = quiet ? 0 : $urandom_range(0, 11);
            end
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
            sb.check_result(out_ch.payload);
            served++;
            @(negedge i_clk);
        end
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("tb_sync_byte_baud_rate_hunter_core: FAIL");
        $finish;
    end

endmodule
